[sv/iqs_pkg.sv]
// ----------------------------------------------------------------------------
// iqs_pkg: shared types and constants for the iterative quicksort block
// Word formats, datapath operation codes and the control/status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package iqs_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam int unsigned VALUE_W       = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      final_res;
  } out_word_t;

  typedef enum logic [4:0] {
    DP_IDLE,
    DP_LOAD,
    DP_START,
    DP_POP,
    DP_RANGE,
    DP_PIVOT,
    DP_SCAN_RD,
    DP_CMP,
    DP_SWAP_A,
    DP_SWAP_B,
    DP_FIN_RD,
    DP_FIN_A,
    DP_FIN_B,
    DP_PUSH_L,
    DP_PUSH_R,
    DP_EMIT_RD,
    DP_EMIT_LD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic in_last;
    logic n_small;
    logic stk_empty;
    logic swap_need;
    logic scan_more;
    logic k_last;
    logic out_free;
  } sts_t;

endpackage

[sv/iterative_quicksort.sv]
// ----------------------------------------------------------------------------
// iterative_quicksort: load, sort and emit a set of signed 32-bit words
// Words are taken one per cycle into a MAX_ITEMS-entry store until a word
// marked last arrives; words beyond capacity are dropped. The set is then
// sorted ascending by an in-place Lomuto quicksort (last element as pivot)
// driven from a stack of bound pairs, and emitted in order with final_res on
// the last word. Sorting runs on the element store's one read port and one
// write port, comparing each element of a range with the pivot and exchanging
// it where needed. Emission reads each word and loads it into the output
// register when that register is free. The input is stalled from the last
// word until the final sorted word has been loaded into the output
// register.
// ----------------------------------------------------------------------------
module iterative_quicksort #(
  parameter int unsigned MAX_ITEMS = iqs_pkg::MAX_ITEMS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  iqs_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output iqs_pkg::out_word_t out_word_o
);

  iqs_pkg::cmd_t cmd;
  iqs_pkg::sts_t sts;

  iqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  iqs_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_word_i   (in_word_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

`ifndef SYNTH
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == iqs_pkg::DP_POP) |-> !sts.stk_empty)
    else $error("range stack popped while empty");

  a_in_only_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (cmd.op == iqs_pkg::DP_LOAD))
    else $error("input word taken outside load");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.op == iqs_pkg::DP_EMIT_LD))
    else $error("output valid without an emit load");
`endif

endmodule

[sv/iqs_ram.sv]
// ----------------------------------------------------------------------------
// iqs_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ----------------------------------------------------------------------------
module iqs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/iqs_dp.sv]
// ----------------------------------------------------------------------------
// iqs_dp: quicksort datapath
// Element store, range stack, partition indices, pivot and the output word
// register. Executes one operation per cycle as commanded by the controller.
// ----------------------------------------------------------------------------
module iqs_dp #(
  parameter int unsigned MAX_ITEMS = iqs_pkg::MAX_ITEMS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iqs_pkg::cmd_t       cmd_i,
  output iqs_pkg::sts_t       sts_o,
  input  iqs_pkg::in_word_t   in_word_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output iqs_pkg::out_word_t  out_word_o
);

  localparam int unsigned IW  = $clog2(MAX_ITEMS);
  localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SD  = MAX_ITEMS / 2;
  localparam int unsigned SAW = (SD > 1) ? $clog2(SD) : 1;
  localparam int unsigned TW  = $clog2(SD + 1);
  localparam int unsigned VW  = iqs_pkg::VALUE_W;

  logic [CW-1:0]              fill_q;
  logic [TW-1:0]              top_q;
  logic                       out_vld_q;
  iqs_pkg::out_word_t         out_q;
  logic [IW-1:0]              lo_q, hi_q, mid_q, idx_q, k_q;
  logic signed [VW-1:0]       pivot_q, elem_q;

  logic                       st_we, st_re;
  logic [IW-1:0]              st_waddr, st_raddr;
  logic [VW-1:0]              st_wdata, st_rdata;
  logic signed [VW-1:0]       st_rval;

  logic                       sk_we, sk_re;
  logic [SAW-1:0]             sk_waddr, sk_raddr;
  logic [2*IW-1:0]            sk_wdata, sk_rdata;
  logic [IW-1:0]              stk_lo, stk_hi;

  logic [CW-1:0]              fill_m1;
  logic [IW-1:0]              n_last_idx;
  logic [TW-1:0]              top_m1;
  logic [IW:0]                lo_x, hi_x, mid_x, idx_x;
  logic                       room, push_l_ok, push_r_ok, le, k_last, out_free;

  assign st_rval    = $signed(st_rdata);
  assign stk_lo     = sk_rdata[2*IW-1:IW];
  assign stk_hi     = sk_rdata[IW-1:0];
  assign fill_m1    = fill_q - CW'(1);
  assign n_last_idx = fill_m1[IW-1:0];
  assign top_m1     = top_q - TW'(1);
  assign lo_x       = {1'b0, lo_q};
  assign hi_x       = {1'b0, hi_q};
  assign mid_x      = {1'b0, mid_q};
  assign idx_x      = {1'b0, idx_q};
  assign room       = fill_q < CW'(MAX_ITEMS);
  assign push_l_ok  = mid_x >= (lo_x + (IW+1)'(2));
  assign push_r_ok  = (mid_x + (IW+1)'(2)) <= hi_x;
  assign le         = st_rval <= pivot_q;
  assign k_last     = k_q == n_last_idx;
  assign out_free   = !out_vld_q || !out_stall_i;

  always_comb begin
    st_we    = 1'b0;
    st_waddr = idx_q;
    st_wdata = st_rdata;
    st_re    = 1'b0;
    st_raddr = idx_q;
    sk_we    = 1'b0;
    sk_waddr = top_q[SAW-1:0];
    sk_wdata = {lo_q, hi_q};
    sk_re    = 1'b0;
    sk_raddr = top_m1[SAW-1:0];
    case (cmd_i.op)
      iqs_pkg::DP_LOAD: begin
        st_we    = room;
        st_waddr = fill_q[IW-1:0];
        st_wdata = in_word_i.value;
      end
      iqs_pkg::DP_START: begin
        sk_we    = 1'b1;
        sk_waddr = '0;
        sk_wdata = {IW'(0), n_last_idx};
      end
      iqs_pkg::DP_POP: begin
        sk_re = 1'b1;
      end
      iqs_pkg::DP_RANGE: begin
        st_re    = 1'b1;
        st_raddr = stk_hi;
      end
      iqs_pkg::DP_SCAN_RD: begin
        st_re    = 1'b1;
        st_raddr = idx_q;
      end
      iqs_pkg::DP_CMP, iqs_pkg::DP_FIN_RD: begin
        st_re    = 1'b1;
        st_raddr = mid_q;
      end
      iqs_pkg::DP_SWAP_A: begin
        st_we    = 1'b1;
        st_waddr = idx_q;
        st_wdata = st_rdata;
      end
      iqs_pkg::DP_SWAP_B: begin
        st_we    = 1'b1;
        st_waddr = mid_q;
        st_wdata = elem_q;
      end
      iqs_pkg::DP_FIN_A: begin
        st_we    = 1'b1;
        st_waddr = hi_q;
        st_wdata = st_rdata;
      end
      iqs_pkg::DP_FIN_B: begin
        st_we    = 1'b1;
        st_waddr = mid_q;
        st_wdata = pivot_q;
      end
      iqs_pkg::DP_PUSH_L: begin
        sk_we    = push_l_ok;
        sk_wdata = {lo_q, mid_q - IW'(1)};
      end
      iqs_pkg::DP_PUSH_R: begin
        sk_we    = push_r_ok;
        sk_wdata = {mid_q + IW'(1), hi_q};
      end
      iqs_pkg::DP_EMIT_RD: begin
        st_re    = 1'b1;
        st_raddr = k_q;
      end
      default: begin
      end
    endcase
  end

  iqs_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // each entry holds one (low, high) bound pair
  iqs_ram #(
    .WIDTH (2*IW),
    .DEPTH (SD)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (sk_we),
    .waddr_i (sk_waddr),
    .wdata_i (sk_wdata),
    .re_i    (sk_re),
    .raddr_i (sk_raddr),
    .rdata_o (sk_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      top_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        iqs_pkg::DP_LOAD:    if (room) fill_q <= fill_q + CW'(1);
        iqs_pkg::DP_START:   top_q <= TW'(1);
        iqs_pkg::DP_POP:     top_q <= top_m1;
        iqs_pkg::DP_PUSH_L:  if (push_l_ok) top_q <= top_q + TW'(1);
        iqs_pkg::DP_PUSH_R:  if (push_r_ok) top_q <= top_q + TW'(1);
        iqs_pkg::DP_EMIT_LD: if (k_last) fill_q <= '0;
        default: begin
        end
      endcase
      if (cmd_i.op == iqs_pkg::DP_EMIT_LD) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      iqs_pkg::DP_START: begin
        k_q <= '0;
      end
      iqs_pkg::DP_RANGE: begin
        lo_q <= stk_lo;
        hi_q <= stk_hi;
      end
      iqs_pkg::DP_PIVOT: begin
        pivot_q <= st_rval;
        mid_q   <= lo_q;
        idx_q   <= lo_q;
      end
      iqs_pkg::DP_CMP: begin
        elem_q <= st_rval;
        if (!le) begin
          idx_q <= idx_q + IW'(1);
        end else if (idx_q == mid_q) begin
          idx_q <= idx_q + IW'(1);
          mid_q <= mid_q + IW'(1);
        end
      end
      iqs_pkg::DP_SWAP_B: begin
        idx_q <= idx_q + IW'(1);
        mid_q <= mid_q + IW'(1);
      end
      iqs_pkg::DP_EMIT_LD: begin
        out_q.sorted_value <= st_rval;
        out_q.final_res    <= k_last;
        k_q                <= k_q + IW'(1);
      end
      default: begin
      end
    endcase
  end

  assign sts_o.in_last   = in_word_i.last;
  assign sts_o.n_small   = fill_q < CW'(2);
  assign sts_o.stk_empty = top_q == '0;
  assign sts_o.swap_need = le && (idx_q != mid_q);
  assign sts_o.scan_more = (idx_x + (IW+1)'(1)) < hi_x;
  assign sts_o.k_last    = k_last;
  assign sts_o.out_free  = out_free;

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

[sv/iqs_ctrl.sv]
// ----------------------------------------------------------------------------
// iqs_ctrl: quicksort controller
// Sequences load, Lomuto partitioning over the range stack, and emission,
// issuing at most one datapath operation per cycle.
// ----------------------------------------------------------------------------
module iqs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output iqs_pkg::cmd_t  cmd_o,
  input  iqs_pkg::sts_t  sts_i
);

  localparam logic [3:0] S_LOAD    = 4'd0;
  localparam logic [3:0] S_START   = 4'd1;
  localparam logic [3:0] S_POP     = 4'd2;
  localparam logic [3:0] S_RANGE   = 4'd3;
  localparam logic [3:0] S_PIVOT   = 4'd4;
  localparam logic [3:0] S_SCAN_RD = 4'd5;
  localparam logic [3:0] S_CMP     = 4'd6;
  localparam logic [3:0] S_SWAP_A  = 4'd7;
  localparam logic [3:0] S_SWAP_B  = 4'd8;
  localparam logic [3:0] S_FIN_RD  = 4'd9;
  localparam logic [3:0] S_FIN_A   = 4'd10;
  localparam logic [3:0] S_FIN_B   = 4'd11;
  localparam logic [3:0] S_PUSH_L  = 4'd12;
  localparam logic [3:0] S_PUSH_R  = 4'd13;
  localparam logic [3:0] S_EMIT_RD = 4'd14;
  localparam logic [3:0] S_EMIT_W  = 4'd15;

  logic [3:0] state_q, state_d;

  assign in_stall_o = state_q != S_LOAD;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = iqs_pkg::DP_IDLE;
    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.op = iqs_pkg::DP_LOAD;
          if (sts_i.in_last) state_d = S_START;
        end
      end
      S_START: begin
        cmd_o.op = iqs_pkg::DP_START;
        state_d  = sts_i.n_small ? S_EMIT_RD : S_POP;
      end
      S_POP: begin
        if (sts_i.stk_empty) begin
          state_d = S_EMIT_RD;
        end else begin
          cmd_o.op = iqs_pkg::DP_POP;
          state_d  = S_RANGE;
        end
      end
      S_RANGE: begin
        cmd_o.op = iqs_pkg::DP_RANGE;
        state_d  = S_PIVOT;
      end
      S_PIVOT: begin
        cmd_o.op = iqs_pkg::DP_PIVOT;
        state_d  = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd_o.op = iqs_pkg::DP_SCAN_RD;
        state_d  = S_CMP;
      end
      S_CMP: begin
        cmd_o.op = iqs_pkg::DP_CMP;
        if (sts_i.swap_need) begin
          state_d = S_SWAP_A;
        end else begin
          state_d = sts_i.scan_more ? S_SCAN_RD : S_FIN_RD;
        end
      end
      S_SWAP_A: begin
        cmd_o.op = iqs_pkg::DP_SWAP_A;
        state_d  = S_SWAP_B;
      end
      S_SWAP_B: begin
        cmd_o.op = iqs_pkg::DP_SWAP_B;
        state_d  = sts_i.scan_more ? S_SCAN_RD : S_FIN_RD;
      end
      S_FIN_RD: begin
        cmd_o.op = iqs_pkg::DP_FIN_RD;
        state_d  = S_FIN_A;
      end
      S_FIN_A: begin
        cmd_o.op = iqs_pkg::DP_FIN_A;
        state_d  = S_FIN_B;
      end
      S_FIN_B: begin
        cmd_o.op = iqs_pkg::DP_FIN_B;
        state_d  = S_PUSH_L;
      end
      S_PUSH_L: begin
        cmd_o.op = iqs_pkg::DP_PUSH_L;
        state_d  = S_PUSH_R;
      end
      S_PUSH_R: begin
        cmd_o.op = iqs_pkg::DP_PUSH_R;
        state_d  = S_POP;
      end
      S_EMIT_RD: begin
        cmd_o.op = iqs_pkg::DP_EMIT_RD;
        state_d  = S_EMIT_W;
      end
      S_EMIT_W: begin
        if (sts_i.out_free) begin
          cmd_o.op = iqs_pkg::DP_EMIT_LD;
          state_d  = sts_i.k_last ? S_LOAD : S_EMIT_RD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[verif/iqs_sort_checker.sv]
// ----------------------------------------------------------------------------
// iqs_sort_checker: predictor and scoreboard for the iterative quicksort
// Watches both channels of the block. Accepted input words are collected per
// set; a word marked last sorts the set with its own Lomuto quicksort and
// queues the sorted words. Each accepted output word is checked field by
// field against the oldest queued word. Reports the failure count and the
// number of words still due.
// ----------------------------------------------------------------------------
module iqs_sort_checker #(
  parameter int unsigned CAP = iqs_pkg::MAX_ITEMS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  iqs_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  iqs_pkg::out_word_t out_word_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  logic signed [iqs_pkg::VALUE_W-1:0] set_buf [CAP];
  int                                 set_fill;
  iqs_pkg::out_word_t                 sorted_q [$];
  int                                 fails = 0;

  initial begin
    set_fill     = 0;
    pending_o    = 0;
    fail_count_o = 0;
  end

  function automatic void sort_set(int n);
    int                                 bounds [$];
    int                                 lo, hi, mid;
    logic signed [iqs_pkg::VALUE_W-1:0] pivot, tmp;
    if (n < 2) return;
    bounds.push_back(0);
    bounds.push_back(n - 1);
    while (bounds.size() >= 2) begin
      hi    = bounds.pop_back();
      lo    = bounds.pop_back();
      pivot = set_buf[hi];
      mid   = lo;
      for (int i = lo; i < hi; i++) begin
        if (set_buf[i] <= pivot) begin
          tmp          = set_buf[i];
          set_buf[i]   = set_buf[mid];
          set_buf[mid] = tmp;
          mid++;
        end
      end
      tmp          = set_buf[mid];
      set_buf[mid] = set_buf[hi];
      set_buf[hi]  = tmp;
      if (mid >= lo + 2) begin
        bounds.push_back(lo);
        bounds.push_back(mid - 1);
      end
      if (mid + 2 <= hi) begin
        bounds.push_back(mid + 1);
        bounds.push_back(hi);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    iqs_pkg::out_word_t want;
    if (!rst_ni) begin
      set_fill = 0;
      sorted_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (sorted_q.size() == 0) begin
          $error("unexpected word: sorted_value %0d final_res %0b",
                 out_word_i.sorted_value, out_word_i.final_res);
          fails++;
        end else begin
          want = sorted_q.pop_front();
          if (out_word_i.sorted_value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d",
                   want.sorted_value, out_word_i.sorted_value);
            fails++;
          end
          if (out_word_i.final_res !== want.final_res) begin
            $error("final_res: expected %0b, got %0b",
                   want.final_res, out_word_i.final_res);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        // words past capacity are dropped
        if (set_fill < CAP) begin
          set_buf[set_fill] = in_word_i.value;
          set_fill++;
        end
        if (in_word_i.last) begin
          sort_set(set_fill);
          for (int k = 0; k < set_fill; k++)
            sorted_q.push_back('{sorted_value: set_buf[k],
                                 final_res: logic'(k == set_fill - 1)});
          set_fill = 0;
        end
      end
    end
    pending_o    <= sorted_q.size();
    fail_count_o <= fails;
  end

endmodule

[verif/tb_iterative_quicksort.sv]
// ----------------------------------------------------------------------------
// tb_iterative_quicksort: testbench for the iterative quicksort block
// Sends directed sets (single words, extremes, duplicates, sorted and reverse
// sorted runs) and then random sets of varied size and shape, including full
// and overflowing sets, with bursty input and a patterned output stall.
// Checking is done by iqs_sort_checker beside the block.
// ----------------------------------------------------------------------------
module tb_iterative_quicksort;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int WORD_TARGET = 420;
  localparam int DRAIN       = 30;
  localparam logic signed [iqs_pkg::VALUE_W-1:0] VMIN = 32'sh8000_0000;
  localparam logic signed [iqs_pkg::VALUE_W-1:0] VMAX = 32'sh7fff_ffff;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  iqs_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_stall;
  iqs_pkg::out_word_t out_word;
  int                 pending;
  int                 fail_count;

  int                 burst_left;
  int                 words_sent;
  int                 cycle_count;
  int                 stall_mode;
  int                 stall_run;

  iterative_quicksort dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  iqs_sort_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // output stall: runs of no stall, random stall and heavy stall
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_run  <= $urandom_range(4, 60);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= $urandom_range(0, 1);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send_word(input logic signed [iqs_pkg::VALUE_W-1:0] v,
                           input logic l);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_word  <= '{value: v, last: l};
    do @(posedge clk); while (in_stall);
    burst_left--;
    words_sent++;
  endtask

  task automatic send_set(input logic signed [iqs_pkg::VALUE_W-1:0] vals [$]);
    foreach (vals[i]) send_word(vals[i], logic'(i == vals.size() - 1));
  endtask

  task automatic send_random_set();
    logic signed [iqs_pkg::VALUE_W-1:0] vals [$];
    logic signed [iqs_pkg::VALUE_W-1:0] base;
    int                                 size_sel, len, shape;
    size_sel = $urandom_range(0, 19);
    if (size_sel == 0) len = iqs_pkg::MAX_ITEMS_DEF;
    else if (size_sel == 1) len = $urandom_range(iqs_pkg::MAX_ITEMS_DEF + 1,
                                                 iqs_pkg::MAX_ITEMS_DEF + 6);
    else len = $urandom_range(1, 16);
    shape = $urandom_range(0, 9);
    base  = $urandom;
    for (int i = 0; i < len; i++) begin
      case (shape)
        0, 1: vals.push_back($signed($urandom_range(0, 8)) - 4);
        2: vals.push_back(base + i);
        3: vals.push_back(base - i);
        4: begin
          case ($urandom_range(0, 3))
            0: vals.push_back(VMIN);
            1: vals.push_back(VMAX);
            2: vals.push_back(0);
            default: vals.push_back(-1);
          endcase
        end
        default: vals.push_back($urandom);
      endcase
    end
    send_set(vals);
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_word     = '0;
    out_stall   = 1'b0;
    burst_left  = 0;
    words_sent  = 0;
    cycle_count = 0;
    stall_mode  = 0;
    stall_run   = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_set({VMAX});
    send_set({VMIN});
    send_set({VMAX, VMIN, 32'sd0, -32'sd1, 32'sd1, VMIN, VMAX});
    send_set({32'sd5, 32'sd5, 32'sd5, 32'sd5});
    send_set({-32'sd2, -32'sd1, 32'sd0, 32'sd1, 32'sd2});
    send_set({VMAX, 32'sd100, 32'sd0, -32'sd100, VMIN});

    while (words_sent < WORD_TARGET) send_random_set();

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
